### hw/rtl/bls_pkg.sv
// Shared constants and types for the Bresenham line stepper.
package bls_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int COLOR_BITS     = 24;

  // Transaction mode codes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Control flags that describe the active line.
  typedef struct packed {
    logic busy;
    logic x_major;
    logic y_down;
  } flags_t;

endpackage

### hw/rtl/bresenham_line_stepper_top.sv
// Top level of the Bresenham line stepper: input register, line state and result register.
// A transaction accepted into the input register shows its pixel on the out_ ports from the result register.
// Throughput: one transaction per cycle unless the result register is full and out_stall holds it.
// A step transaction with no active line is consumed and produces no result.
// Reset (rst_n low, synchronous) empties both stages and clears the line state to zero.
module bresenham_line_stepper_top #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [COORD_BITS-1:0]          in_start_x,
  input  logic [COORD_BITS-1:0]          in_start_y,
  input  logic [COORD_BITS-1:0]          in_end_x,
  input  logic [COORD_BITS-1:0]          in_end_y,
  input  logic [bls_pkg::COLOR_BITS-1:0] in_line_color,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COORD_BITS-1:0]          out_pixel_x,
  output logic [COORD_BITS-1:0]          out_pixel_y,
  output logic [bls_pkg::COLOR_BITS-1:0] out_pixel_color,
  output logic                           out_last_pixel
);

  localparam int DW = COORD_BITS + 3;

  // Input register stage. It holds one transaction until the result stage can move.
  logic                           s1_valid_r;
  logic                           s1_mode_r;
  logic [COORD_BITS-1:0]          s1_start_x_r, s1_start_y_r, s1_end_x_r, s1_end_y_r;
  logic [bls_pkg::COLOR_BITS-1:0] s1_color_r;

  // Line state, updated once for every transaction that leaves the input register.
  logic [COORD_BITS-1:0]          cur_x_r, cur_y_r, stop_x_r, stop_y_r;
  logic [COORD_BITS-1:0]          delta_x_r, delta_y_r;
  logic signed [DW-1:0]           decision_r;
  bls_pkg::flags_t                flags_r;
  logic [bls_pkg::COLOR_BITS-1:0] held_color_r;

  logic [COORD_BITS-1:0]          cur_x_nxt, cur_y_nxt, stop_x_nxt, stop_y_nxt;
  logic [COORD_BITS-1:0]          delta_x_nxt, delta_y_nxt;
  logic signed [DW-1:0]           decision_nxt;
  bls_pkg::flags_t                flags_nxt;
  logic [bls_pkg::COLOR_BITS-1:0] held_color_nxt;
  logic                           emit, last;

  // Result register.
  logic                           out_valid_r;
  logic [COORD_BITS-1:0]          out_pixel_x_r, out_pixel_y_r;
  logic [bls_pkg::COLOR_BITS-1:0] out_pixel_color_r;
  logic                           out_last_pixel_r;

  logic adv;
  logic in_fire;
  logic s1_fire;

  // The result stage can take a new pixel when it is empty or its pixel leaves this cycle.
  // The input register therefore drains every cycle unless the output is full and stalled,
  // so a new transaction is taken while the previous one is still being processed.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_fire  = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && adv;

  bls_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .mode         (s1_mode_r),
    .start_x      (s1_start_x_r),
    .start_y      (s1_start_y_r),
    .end_x        (s1_end_x_r),
    .end_y        (s1_end_y_r),
    .cur_x        (cur_x_r),
    .cur_y        (cur_y_r),
    .stop_x       (stop_x_r),
    .stop_y       (stop_y_r),
    .delta_x      (delta_x_r),
    .delta_y      (delta_y_r),
    .decision     (decision_r),
    .flags        (flags_r),
    .cur_x_nxt    (cur_x_nxt),
    .cur_y_nxt    (cur_y_nxt),
    .stop_x_nxt   (stop_x_nxt),
    .stop_y_nxt   (stop_y_nxt),
    .delta_x_nxt  (delta_x_nxt),
    .delta_y_nxt  (delta_y_nxt),
    .decision_nxt (decision_nxt),
    .flags_nxt    (flags_nxt),
    .emit         (emit),
    .last         (last)
  );

  // A load transaction captures its color; steps reuse the held color.
  assign held_color_nxt = (s1_mode_r == bls_pkg::MODE_LOAD) ? s1_color_r : held_color_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r    <= in_mode;
      s1_start_x_r <= in_start_x;
      s1_start_y_r <= in_start_y;
      s1_end_x_r   <= in_end_x;
      s1_end_y_r   <= in_end_y;
      s1_color_r   <= in_line_color;
    end
  end

  // Line state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      stop_x_r     <= '0;
      stop_y_r     <= '0;
      delta_x_r    <= '0;
      delta_y_r    <= '0;
      decision_r   <= '0;
      flags_r      <= '0;
      held_color_r <= '0;
    end else if (s1_fire) begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      stop_x_r     <= stop_x_nxt;
      stop_y_r     <= stop_y_nxt;
      delta_x_r    <= delta_x_nxt;
      delta_y_r    <= delta_y_nxt;
      decision_r   <= decision_nxt;
      flags_r      <= flags_nxt;
      held_color_r <= held_color_nxt;
    end
  end

  // Result register. A step with no active line moves through without filling it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_pixel_x_r     <= cur_x_nxt;
      out_pixel_y_r     <= cur_y_nxt;
      out_pixel_color_r <= held_color_nxt;
      out_last_pixel_r  <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_pixel_x_r;
  assign out_pixel_y     = out_pixel_y_r;
  assign out_pixel_color = out_pixel_color_r;
  assign out_last_pixel  = out_last_pixel_r;

`ifndef SYNTHESIS
  // The input side only stalls when a transaction is waiting in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  // The line goes inactive only together with a delivered last pixel.
  a_busy_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(flags_r.busy)) |-> (out_valid_r && out_last_pixel_r))
    else $error("line ended without a last pixel");

  // A step with no active line produces no result.
  a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_mode_r == bls_pkg::MODE_STEP) && !flags_r.busy) |=> !out_valid_r)
    else $error("idle step produced a pixel");

  // A load emits the endpoint with the smaller x first.
  a_load_first_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_mode_r == bls_pkg::MODE_LOAD)) |=>
      (out_valid_r && (out_pixel_x_r <= $past(s1_start_x_r))
                   && (out_pixel_x_r <= $past(s1_end_x_r))))
    else $error("load did not emit the leftmost endpoint");
`endif

endmodule

### hw/rtl/bls_step.sv
// Combinational line setup and midpoint step logic for the Bresenham line stepper.
module bls_step #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic                         mode,
  input  logic [COORD_BITS-1:0]        start_x,
  input  logic [COORD_BITS-1:0]        start_y,
  input  logic [COORD_BITS-1:0]        end_x,
  input  logic [COORD_BITS-1:0]        end_y,
  input  logic [COORD_BITS-1:0]        cur_x,
  input  logic [COORD_BITS-1:0]        cur_y,
  input  logic [COORD_BITS-1:0]        stop_x,
  input  logic [COORD_BITS-1:0]        stop_y,
  input  logic [COORD_BITS-1:0]        delta_x,
  input  logic [COORD_BITS-1:0]        delta_y,
  input  logic signed [COORD_BITS+2:0] decision,
  input  bls_pkg::flags_t              flags,
  output logic [COORD_BITS-1:0]        cur_x_nxt,
  output logic [COORD_BITS-1:0]        cur_y_nxt,
  output logic [COORD_BITS-1:0]        stop_x_nxt,
  output logic [COORD_BITS-1:0]        stop_y_nxt,
  output logic [COORD_BITS-1:0]        delta_x_nxt,
  output logic [COORD_BITS-1:0]        delta_y_nxt,
  output logic signed [COORD_BITS+2:0] decision_nxt,
  output bls_pkg::flags_t              flags_nxt,
  output logic                         emit,
  output logic                         last
);

  localparam int DW = COORD_BITS + 3;

  // Line setup.
  logic                  swap;
  logic [COORD_BITS-1:0] lo_x, lo_y, hi_x, hi_y;
  logic [COORD_BITS-1:0] ld_dx, ld_dy;
  logic                  ld_y_down, ld_x_major, ld_last;
  logic [DW-1:0]         ld_dec;

  // Stepping.
  logic                  dec_pos;
  logic [DW-1:0]         dx2, dy2;
  logic [COORD_BITS-1:0] x_inc, y_adv;
  logic [COORD_BITS-1:0] st_x, st_y;
  logic [DW-1:0]         st_dec;
  logic                  st_last;

  always_comb begin
    swap = (start_x > end_x) || ((start_x == end_x) && (start_y > end_y));
    lo_x = swap ? end_x   : start_x;
    lo_y = swap ? end_y   : start_y;
    hi_x = swap ? start_x : end_x;
    hi_y = swap ? start_y : end_y;

    ld_dx      = hi_x - lo_x;
    ld_y_down  = (hi_y < lo_y);
    ld_dy      = ld_y_down ? (lo_y - hi_y) : (hi_y - lo_y);
    ld_x_major = (ld_dx >= ld_dy);
    if (ld_x_major) begin
      ld_dec = {2'b00, ld_dy, 1'b0} - {3'b000, ld_dx};
    end else begin
      ld_dec = {2'b00, ld_dx, 1'b0} - {3'b000, ld_dy};
    end
    ld_last = ld_x_major ? (lo_x == hi_x) : (lo_y == hi_y);
  end

  always_comb begin
    dec_pos = !decision[DW-1] && (decision != '0);
    dx2     = {2'b00, delta_x, 1'b0};
    dy2     = {2'b00, delta_y, 1'b0};
    x_inc   = cur_x + COORD_BITS'(1);
    y_adv   = flags.y_down ? (cur_y - COORD_BITS'(1)) : (cur_y + COORD_BITS'(1));
    if (flags.x_major) begin
      st_x   = x_inc;
      st_y   = dec_pos ? y_adv : cur_y;
      st_dec = decision - (dec_pos ? dx2 : '0) + dy2;
    end else begin
      st_y   = y_adv;
      st_x   = dec_pos ? x_inc : cur_x;
      st_dec = decision - (dec_pos ? dy2 : '0) + dx2;
    end
    st_last = flags.x_major ? (st_x == stop_x) : (st_y == stop_y);
  end

  always_comb begin
    cur_x_nxt    = cur_x;
    cur_y_nxt    = cur_y;
    stop_x_nxt   = stop_x;
    stop_y_nxt   = stop_y;
    delta_x_nxt  = delta_x;
    delta_y_nxt  = delta_y;
    decision_nxt = decision;
    flags_nxt    = flags;
    emit         = 1'b0;
    last         = 1'b0;
    if (mode == bls_pkg::MODE_LOAD) begin
      cur_x_nxt         = lo_x;
      cur_y_nxt         = lo_y;
      stop_x_nxt        = hi_x;
      stop_y_nxt        = hi_y;
      delta_x_nxt       = ld_dx;
      delta_y_nxt       = ld_dy;
      decision_nxt      = ld_dec;
      flags_nxt.busy    = !ld_last;
      flags_nxt.x_major = ld_x_major;
      flags_nxt.y_down  = ld_y_down;
      emit              = 1'b1;
      last              = ld_last;
    end else if (flags.busy) begin
      cur_x_nxt      = st_x;
      cur_y_nxt      = st_y;
      decision_nxt   = st_dec;
      flags_nxt.busy = !st_last;
      emit           = 1'b1;
      last           = st_last;
    end
  end

endmodule
